[design/ogm_pkg.sv]
// ----------------------------------------------------------------------------
// ogm_pkg
// Shared sizes, codes and helpers for the occupancy grid marker core.
// ----------------------------------------------------------------------------
`default_nettype none

package ogm_pkg;

   // Grid storage size and largest usable side length
   localparam int CELL_COUNT = 65536;
   localparam int MAX_SIDE   = 256;

   // Cell address width, cell coordinate width, side length width
   localparam int IDX_W  = $clog2(CELL_COUNT);
   localparam int CELL_W = $clog2(MAX_SIDE);
   localparam int SIDE_W = CELL_W + 1;
   // Width of y * width + x before the range check
   localparam int SUM_W  = CELL_W + SIDE_W + 1;

   // Fixed field widths
   localparam int POS_W   = 24;
   localparam int CPM_W   = 24;
   localparam int GRID_W  = 9;
   localparam int PROD_W  = 2 * POS_W;
   localparam int VALUE_W = 8;
   localparam int RIDX_W  = 16;
   localparam int CSR_W   = 3;

   // Output cell values
   localparam logic signed [VALUE_W-1:0] VAL_UNKNOWN = -8'sd1;
   localparam logic signed [VALUE_W-1:0] VAL_FREE    = 8'sd0;
   localparam logic signed [VALUE_W-1:0] VAL_OCC     = 8'sd100;

   typedef enum logic [1:0] {
      FUNC_CLEAR  = 2'd0,
      FUNC_FREE   = 2'd1,
      FUNC_HAZARD = 2'd2,
      FUNC_READ   = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      CODE_UNKNOWN = 2'd0,
      CODE_FREE    = 2'd1,
      CODE_OCC     = 2'd2
   } cell_code_type;

   typedef enum logic [CSR_W-1:0] {
      CSR_ORIGIN_X    = 3'd0,
      CSR_ORIGIN_Y    = 3'd1,
      CSR_CELLS_PER_M = 3'd2,
      CSR_GRID_WIDTH  = 3'd3,
      CSR_GRID_HEIGHT = 3'd4
   } csr_reg_type;

   // Map a stored cell code to its reported value
   function automatic logic signed [VALUE_W-1:0] code_value(input logic [1:0] code);
      logic signed [VALUE_W-1:0] v;
      case (code)
         CODE_FREE: v = VAL_FREE;
         CODE_OCC:  v = VAL_OCC;
         default:   v = VAL_UNKNOWN;
      endcase
      return v;
   endfunction

   // Limit a side length to the largest usable side
   function automatic logic [SIDE_W-1:0] side_limit(input logic [GRID_W-1:0] s);
      logic [SIDE_W-1:0] r;
      if (32'(s) > 32'(MAX_SIDE)) begin
         r = SIDE_W'(MAX_SIDE);
      end else begin
         r = SIDE_W'(s);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

[design/occupancy_grid_marker_core.sv]
// A mark item passes ST_DIFF, ST_MULX, ST_MULY, ST_CHKY, ST_INDEX, ST_WRITE and ST_OUT; a read
// passes ST_READ, ST_RDATA and ST_OUT; a clear sweeps the store (one entry written per cycle).
// One item at a time; the next input is taken in ST_IDLE, the cycle after the result is loaded.
// The 24x24 multiply serves x then y, both through the one product register prod_ff.
// Reset: control clears and a sweep of all 65536 entries sets every cell unknown; no input is
// taken during the sweep, configuration writes are taken at all times.
// ----------------------------------------------------------------------------
// occupancy_grid_marker_core
// Marks free and hazard points into a 2-D occupancy grid held in one
// synchronous memory, answers cell reads and clears the whole grid.
// ----------------------------------------------------------------------------
`default_nettype none

module occupancy_grid_marker_core (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // input item channel
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic [1:0]                            req_func,
   input  wire logic signed [ogm_pkg::POS_W-1:0]      req_point_x,
   input  wire logic signed [ogm_pkg::POS_W-1:0]      req_point_y,
   input  wire logic [ogm_pkg::RIDX_W-1:0]            req_read_index,
   // result channel
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic signed [ogm_pkg::VALUE_W-1:0]         rsp_cell_value,
   output logic [ogm_pkg::RIDX_W-1:0]                 rsp_cell_index,
   output logic                                       rsp_in_map,
   // configuration write channel
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [ogm_pkg::CSR_W-1:0]             csr_index,
   input  wire logic [ogm_pkg::POS_W-1:0]             csr_data
);

   typedef enum logic [3:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_DIFF,
      ST_MULX,
      ST_MULY,
      ST_CHKY,
      ST_INDEX,
      ST_WRITE,
      ST_READ,
      ST_RDATA,
      ST_OUT
   } state_type;

   state_type state_ff;

   // Configuration registers
   logic signed [ogm_pkg::POS_W-1:0] origin_x_ff;
   logic signed [ogm_pkg::POS_W-1:0] origin_y_ff;
   logic [ogm_pkg::CPM_W-1:0]        cpm_ff;
   logic [ogm_pkg::GRID_W-1:0]       grid_width_ff;
   logic [ogm_pkg::GRID_W-1:0]       grid_height_ff;

   // Item registers
   logic                              hazard_ff;
   logic signed [ogm_pkg::POS_W-1:0]  point_x_ff;
   logic signed [ogm_pkg::POS_W-1:0]  point_y_ff;
   logic [ogm_pkg::POS_W-1:0]         mag_x_ff;
   logic [ogm_pkg::POS_W-1:0]         mag_y_ff;
   logic                              neg_x_ff;
   logic                              neg_y_ff;
   logic [ogm_pkg::PROD_W-1:0]        prod_ff;
   logic [ogm_pkg::CELL_W-1:0]        cx_ff;
   logic [ogm_pkg::CELL_W-1:0]        cy_ff;
   logic                              ok_x_ff;
   logic                              ok_y_ff;
   logic [ogm_pkg::SUM_W-1:0]         idx_ff;
   logic [ogm_pkg::RIDX_W-1:0]        read_index_ff;
   logic                              read_ok_ff;

   // Sweep control
   logic [ogm_pkg::IDX_W-1:0]         sweep_addr_ff;
   logic                              sweep_clear_ff;

   // Pending result and output registers
   logic signed [ogm_pkg::VALUE_W-1:0] res_value_ff;
   logic [ogm_pkg::RIDX_W-1:0]         res_index_ff;
   logic                               res_in_map_ff;
   logic                               rsp_valid_ff;
   logic signed [ogm_pkg::VALUE_W-1:0] rsp_value_ff;
   logic [ogm_pkg::RIDX_W-1:0]         rsp_index_ff;
   logic                               rsp_in_map_ff;

   // Cell store
   logic [1:0]                 cell_mem [ogm_pkg::CELL_COUNT];
   logic [1:0]                 rd_data_ff;
   logic                       mem_we_in;
   logic [ogm_pkg::IDX_W-1:0]  mem_waddr_in;
   logic [1:0]                 mem_wdata_in;
   logic [ogm_pkg::IDX_W-1:0]  mem_raddr_in;

   // Combinational helpers
   logic                              req_xfer;
   logic                              csr_xfer;
   logic                              out_free;
   logic [ogm_pkg::SIDE_W-1:0]        w_sat;
   logic [ogm_pkg::SIDE_W-1:0]        h_sat;
   logic signed [ogm_pkg::POS_W:0]    dx;
   logic signed [ogm_pkg::POS_W:0]    dy;
   logic [ogm_pkg::POS_W-1:0]         cell_c;
   logic                              ok_x_c;
   logic                              ok_y_c;
   logic                              mark_ok;
   logic [1:0]                        mark_code;

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign req_xfer  = req_valid && req_ready;
   assign csr_xfer  = csr_valid && csr_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cell_value = rsp_value_ff;
   assign rsp_cell_index = rsp_index_ff;
   assign rsp_in_map     = rsp_in_map_ff;

   // Clip side lengths and form origin offsets
   always_comb begin
      w_sat = ogm_pkg::side_limit(grid_width_ff);
      h_sat = ogm_pkg::side_limit(grid_height_ff);
      dx = (ogm_pkg::POS_W+1)'(point_x_ff) - (ogm_pkg::POS_W+1)'(origin_x_ff);
      dy = (ogm_pkg::POS_W+1)'(point_y_ff) - (ogm_pkg::POS_W+1)'(origin_y_ff);
   end

   // Range check of the truncated product; the axis under test follows the state
   always_comb begin
      cell_c = prod_ff[ogm_pkg::PROD_W-1:ogm_pkg::POS_W];
      ok_x_c = !(neg_x_ff && (cell_c != '0)) && (32'(cell_c) < 32'(w_sat));
      ok_y_c = !(neg_y_ff && (cell_c != '0)) && (32'(cell_c) < 32'(h_sat));
      mark_ok = ok_x_ff && ok_y_ff && (32'(idx_ff) < 32'(ogm_pkg::CELL_COUNT));
      mark_code = hazard_ff ? ogm_pkg::CODE_OCC : ogm_pkg::CODE_FREE;
   end

   // Memory port control: sweep writes unknown, a mark in range writes its code
   always_comb begin
      mem_we_in    = 1'b0;
      mem_waddr_in = sweep_addr_ff;
      mem_wdata_in = ogm_pkg::CODE_UNKNOWN;
      mem_raddr_in = ogm_pkg::IDX_W'(read_index_ff);
      case (state_ff)
         ST_SWEEP: begin
            mem_we_in = 1'b1;
         end
         ST_WRITE: begin
            mem_we_in    = mark_ok;
            mem_waddr_in = ogm_pkg::IDX_W'(idx_ff);
            mem_wdata_in = mark_code;
         end
         default: begin
            mem_we_in = 1'b0;
         end
      endcase
   end

   // Cell store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we_in) begin
         cell_mem[mem_waddr_in] <= mem_wdata_in;
      end
      rd_data_ff <= cell_mem[mem_raddr_in];
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff    <= 24'sd256;
         origin_y_ff    <= -24'sd2048;
         cpm_ff         <= 24'd655360;
         grid_width_ff  <= 9'd80;
         grid_height_ff <= 9'd160;
      end else if (csr_xfer) begin
         case (ogm_pkg::csr_reg_type'(csr_index))
            ogm_pkg::CSR_ORIGIN_X:    origin_x_ff    <= csr_data;
            ogm_pkg::CSR_ORIGIN_Y:    origin_y_ff    <= csr_data;
            ogm_pkg::CSR_CELLS_PER_M: cpm_ff         <= csr_data;
            ogm_pkg::CSR_GRID_WIDTH:  grid_width_ff  <= csr_data[ogm_pkg::GRID_W-1:0];
            ogm_pkg::CSR_GRID_HEIGHT: grid_height_ff <= csr_data[ogm_pkg::GRID_W-1:0];
            default: ;
         endcase
      end
   end

   // Sequencer with item and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_SWEEP;
         sweep_addr_ff  <= '0;
         sweep_clear_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         // drop the result once transferred, unless a new one is loaded now
         if (rsp_valid_ff && rsp_ready && (state_ff != ST_OUT)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_SWEEP: begin
               sweep_addr_ff <= sweep_addr_ff + 1'b1;
               if (sweep_addr_ff == ogm_pkg::IDX_W'(ogm_pkg::CELL_COUNT - 1)) begin
                  state_ff <= sweep_clear_ff ? ST_OUT : ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (req_xfer) begin
                  point_x_ff    <= req_point_x;
                  point_y_ff    <= req_point_y;
                  read_index_ff <= req_read_index;
                  hazard_ff     <= (req_func == ogm_pkg::FUNC_HAZARD);
                  case (ogm_pkg::func_type'(req_func))
                     ogm_pkg::FUNC_CLEAR: begin
                        sweep_addr_ff  <= '0;
                        sweep_clear_ff <= 1'b1;
                        res_value_ff   <= ogm_pkg::VAL_UNKNOWN;
                        res_index_ff   <= '0;
                        res_in_map_ff  <= 1'b0;
                        state_ff       <= ST_SWEEP;
                     end
                     ogm_pkg::FUNC_READ: begin
                        read_ok_ff <= (32'(req_read_index) < 32'(ogm_pkg::CELL_COUNT));
                        state_ff   <= ST_READ;
                     end
                     default: begin
                        state_ff <= ST_DIFF;
                     end
                  endcase
               end
            end
            ST_DIFF: begin
               // magnitude and sign of the offset from the origin
               neg_x_ff <= dx[ogm_pkg::POS_W];
               neg_y_ff <= dy[ogm_pkg::POS_W];
               mag_x_ff <= ogm_pkg::POS_W'(dx[ogm_pkg::POS_W] ? -dx : dx);
               mag_y_ff <= ogm_pkg::POS_W'(dy[ogm_pkg::POS_W] ? -dy : dy);
               state_ff <= ST_MULX;
            end
            ST_MULX: begin
               prod_ff  <= ogm_pkg::PROD_W'(mag_x_ff) * ogm_pkg::PROD_W'(cpm_ff);
               state_ff <= ST_MULY;
            end
            ST_MULY: begin
               cx_ff    <= ogm_pkg::CELL_W'(cell_c);
               ok_x_ff  <= ok_x_c;
               prod_ff  <= ogm_pkg::PROD_W'(mag_y_ff) * ogm_pkg::PROD_W'(cpm_ff);
               state_ff <= ST_CHKY;
            end
            ST_CHKY: begin
               cy_ff    <= ogm_pkg::CELL_W'(cell_c);
               ok_y_ff  <= ok_y_c;
               state_ff <= ST_INDEX;
            end
            ST_INDEX: begin
               idx_ff <= ogm_pkg::SUM_W'(cy_ff) * ogm_pkg::SUM_W'(w_sat)
                         + ogm_pkg::SUM_W'(cx_ff);
               state_ff <= ST_WRITE;
            end
            ST_WRITE: begin
               if (mark_ok) begin
                  res_value_ff  <= ogm_pkg::code_value(mark_code);
                  res_index_ff  <= ogm_pkg::RIDX_W'(idx_ff);
                  res_in_map_ff <= 1'b1;
               end else begin
                  res_value_ff  <= ogm_pkg::VAL_FREE;
                  res_index_ff  <= '0;
                  res_in_map_ff <= 1'b0;
               end
               state_ff <= ST_OUT;
            end
            ST_READ: begin
               // read data lands in rd_data_ff at this edge
               state_ff <= ST_RDATA;
            end
            ST_RDATA: begin
               res_value_ff  <= read_ok_ff ? ogm_pkg::code_value(rd_data_ff)
                                           : ogm_pkg::VAL_UNKNOWN;
               res_index_ff  <= read_index_ff;
               res_in_map_ff <= 1'b0;
               state_ff      <= ST_OUT;
            end
            ST_OUT: begin
               // hold until the output register is free, then load it
               if (out_free) begin
                  rsp_valid_ff   <= 1'b1;
                  rsp_value_ff   <= res_value_ff;
                  rsp_index_ff   <= res_index_ff;
                  rsp_in_map_ff  <= res_in_map_ff;
                  sweep_clear_ff <= 1'b0;
                  state_ff       <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

`default_nettype wire
